// ----- rtl/mrr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types, constants and the CRC-16 step for the register responder.
// ----------------------------------------------------------------------------
package mrr_pkg;

  localparam int MAX_REGS    = 28;
  localparam int VALUE_SLOTS = 16;

  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [7:0]  FUNC_READ_HR = 8'h03;

  localparam logic [15:0] START_VOLT   = 16'h0100;
  localparam logic [15:0] START_CURR   = 16'h0120;
  localparam logic [15:0] START_REACT  = 16'h014E;
  localparam logic [15:0] START_FACTOR = 16'h0132;
  localparam logic [15:0] START_DO_A   = 16'h2100;
  localparam logic [15:0] START_DO_B   = 16'h2000;

  typedef enum logic [1:0] {
    OP_RX_BYTE   = 2'd0,
    OP_FRAME_END = 2'd1,
    OP_VALUE_WR  = 2'd2
  } mrr_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_DECIDE,
    ST_SEND
  } mrr_state_t;

  typedef struct packed {
    logic req_wr;
    logic tbl_wr;
    logic clear;
    logic chk_start;
    logic chk_step;
    logic send_start;
    logic send_step;
  } mrr_cmd_t;

  typedef struct packed {
    logic chk_last;
    logic req_ok;
    logic send_last;
  } mrr_sts_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrr_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  rx_byte;
  logic [3:0]  value_index;
  logic [31:0] value_bits;

  modport source (output valid, output op, output rx_byte, output value_index,
                  output value_bits, input ready);
  modport sink (input valid, input op, input rx_byte, input value_index,
                input value_bits, output ready);
endinterface

interface mrr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

interface mrr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] slave_address;

  modport source (output valid, output slave_address, input ready);
  modport sink (input valid, input slave_address, output ready);
endinterface

// ----- rtl/mrr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_datapath
// Request buffer, value table, crc unit, request check and response byte
// generation with the output payload register.
// ----------------------------------------------------------------------------
module mrr_datapath
  import mrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mrr_cmd_t    cmd,
  output mrr_sts_t    sts,
  input  logic [7:0]  rx_byte,
  input  logic [3:0]  value_index,
  input  logic [31:0] value_bits,
  input  logic        cfg_wr,
  input  logic [7:0]  cfg_addr,
  output logic [7:0]  tx_byte,
  output logic        last_byte
);

  logic [7:0]  req_r [8];
  logic [3:0]  byte_cnt_r;
  logic [31:0] value_table_r [VALUE_SLOTS];
  logic [7:0]  slave_addr_r;
  logic [15:0] crc_r;
  logic [2:0]  chk_cnt_r;
  logic [5:0]  k_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic [15:0] start_addr;
  logic [15:0] qty;
  logic [4:0]  qty5;
  logic [5:0]  nbytes;
  logic [5:0]  data_end;
  logic [3:0]  base;
  logic [2:0]  grp_count;
  logic        little;
  logic        known;
  logic [5:0]  p;
  logic [3:0]  j;
  logic [1:0]  b;
  logic [3:0]  pairs;
  logic [3:0]  slot;
  logic [31:0] w;
  logic [7:0]  cur_byte;
  logic        is_last;
  logic        crc_en;

  // request decode
  always_comb begin
    start_addr = {req_r[2], req_r[3]};
    qty        = {req_r[4], req_r[5]};
    qty5       = qty[4:0];
    nbytes     = {qty5, 1'b0};
    data_end   = 6'd3 + nbytes;
    base       = 4'd0;
    grp_count  = 3'd0;
    little     = 1'b0;
    known      = 1'b1;
    if (start_addr == START_VOLT) begin
      base = 4'd0;  grp_count = 3'd3;
    end else if (start_addr == START_CURR) begin
      base = 4'd3;  grp_count = 3'd3;
    end else if (start_addr == START_REACT) begin
      base = 4'd6;  grp_count = 3'd3;
    end else if (start_addr == START_FACTOR) begin
      base = 4'd9;  grp_count = 3'd4;
    end else if (start_addr == START_DO_A || start_addr == START_DO_B) begin
      base = (qty == 16'd2) ? 4'd13 : 4'd14;
      grp_count = 3'd4;
      little = 1'b1;
    end else begin
      known = 1'b0;
    end
  end

  assign sts.chk_last = (chk_cnt_r == 3'd5);
  assign sts.req_ok   = (req_r[0] == slave_addr_r) && (req_r[1] == FUNC_READ_HR)
                     && (req_r[6] == crc_r[7:0]) && (req_r[7] == crc_r[15:8])
                     && known && (qty != 16'd0) && (qty <= 16'(MAX_REGS));

  // response byte at position k_r
  always_comb begin
    p        = k_r - 6'd3;
    j        = p[5:2];
    b        = p[1:0];
    pairs    = qty5[4:1];
    slot     = little ? base : (base + j);
    w        = value_table_r[slot];
    is_last  = 1'b0;
    crc_en   = 1'b0;
    cur_byte = 8'h00;
    if (k_r == 6'd0) begin
      cur_byte = slave_addr_r;
      crc_en   = 1'b1;
    end else if (k_r == 6'd1) begin
      cur_byte = FUNC_READ_HR;
      crc_en   = 1'b1;
    end else if (k_r == 6'd2) begin
      cur_byte = {2'b00, nbytes};
      crc_en   = 1'b1;
    end else if (k_r < data_end) begin
      crc_en = 1'b1;
      if (j < pairs && j < {1'b0, grp_count}) begin
        if (little) begin
          case (b)
            2'd0:    cur_byte = w[7:0];
            2'd1:    cur_byte = w[15:8];
            2'd2:    cur_byte = w[23:16];
            default: cur_byte = w[31:24];
          endcase
        end else begin
          case (b)
            2'd0:    cur_byte = w[15:8];
            2'd1:    cur_byte = w[7:0];
            2'd2:    cur_byte = w[31:24];
            default: cur_byte = w[23:16];
          endcase
        end
      end
    end else if (k_r == data_end) begin
      cur_byte = crc_r[7:0];
    end else begin
      cur_byte = crc_r[15:8];
      is_last  = 1'b1;
    end
  end

  assign sts.send_last = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        req_r[i] <= 8'h00;
      end
      byte_cnt_r <= 4'd0;
    end else if (cmd.clear) begin
      for (int i = 0; i < 8; i++) begin
        req_r[i] <= 8'h00;
      end
      byte_cnt_r <= 4'd0;
    end else if (cmd.req_wr && byte_cnt_r < 4'd8) begin
      req_r[byte_cnt_r[2:0]] <= rx_byte;
      byte_cnt_r             <= byte_cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VALUE_SLOTS; i++) begin
        value_table_r[i] <= 32'h0;
      end
    end else if (cmd.tbl_wr && 32'(value_index) < VALUE_SLOTS) begin
      value_table_r[value_index] <= value_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
    end else if (cfg_wr) begin
      slave_addr_r <= cfg_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_INIT;
      chk_cnt_r <= 3'd0;
      k_r       <= 6'd0;
    end else if (cmd.chk_start) begin
      crc_r     <= CRC_INIT;
      chk_cnt_r <= 3'd0;
    end else if (cmd.chk_step) begin
      crc_r     <= crc16_update(crc_r, req_r[chk_cnt_r]);
      chk_cnt_r <= chk_cnt_r + 3'd1;
    end else if (cmd.send_start) begin
      crc_r <= CRC_INIT;
      k_r   <= 6'd0;
    end else if (cmd.send_step) begin
      if (crc_en) begin
        crc_r <= crc16_update(crc_r, cur_byte);
      end
      k_r <= k_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send_step) begin
      out_byte_r <= cur_byte;
      out_last_r <= is_last;
    end
  end

  assign tx_byte   = out_byte_r;
  assign last_byte = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= 4'd8)
    else $error("request byte count out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> byte_cnt_r == 4'd0 && req_r[0] == 8'h00)
    else $error("request buffer not cleared");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send_step && is_last |=> out_last_r && out_byte_r == $past(crc_r[15:8]))
    else $error("final crc byte wrong");
`endif

endmodule

// ----- rtl/mrr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_ctrl
// Sequencer: request intake, crc check pass, decision and response stream,
// plus the response valid flag.
// ----------------------------------------------------------------------------
module mrr_ctrl
  import mrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output mrr_cmd_t   cmd,
  input  mrr_sts_t   sts
);

  mrr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_RX_BYTE:   cmd.req_wr = 1'b1;
            OP_FRAME_END: begin
              cmd.chk_start = 1'b1;
              state_nxt     = ST_CHK;
            end
            OP_VALUE_WR:  cmd.tbl_wr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_CHK: begin
        cmd.chk_step = 1'b1;
        if (sts.chk_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.req_ok) begin
          cmd.send_start = 1'b1;
          state_nxt      = ST_SEND;
        end else begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (!out_valid_r || out_ready) begin
          cmd.send_step = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.send_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_FRAME_END |=> state_r == ST_CHK)
    else $error("frame end did not start check");

  a_chk_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHK && sts.chk_last |=> state_r == ST_DECIDE)
    else $error("check pass did not end");

  a_send_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send_step && sts.send_last |=> state_r == ST_IDLE && out_valid_r)
    else $error("response end not handled");
`endif

endmodule

// ----- rtl/modbus_read_register_responder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_read_register_responder_unit
// Function 3 slave: buffers request bytes, keeps a value table and streams
// the response frame with its crc.
//
//   channel  dir  payload                                   transfer
//   in_      in   op, rx_byte, value_index, value_bits      valid & ready
//   out_     out  tx_byte, last_byte                        valid & ready
//   cfg_     in   slave_address                             valid & ready
//
// byte and value items are taken one per cycle while the sequencer is idle
// frame end: a crc pass over the first six request bytes, a decision, then one
// response byte per cycle (5 + 2 * quantity bytes) while out_ready is high
// a rejected frame is dropped; a stalled output holds the sequencer
// synchronous active-low reset; value table cleared, station address 1
// ----------------------------------------------------------------------------
module modbus_read_register_responder_unit
  import mrr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mrr_in_if.sink    in_chan,
  mrr_out_if.source out_chan,
  mrr_cfg_if.sink   cfg_chan
);

  mrr_cmd_t cmd;
  mrr_sts_t sts;
  logic     cfg_wr;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid;

  mrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.op),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mrr_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .rx_byte     (in_chan.rx_byte),
    .value_index (in_chan.value_index),
    .value_bits  (in_chan.value_bits),
    .cfg_wr      (cfg_wr),
    .cfg_addr    (cfg_chan.slave_address),
    .tx_byte     (out_chan.tx_byte),
    .last_byte   (out_chan.last_byte)
  );

endmodule
